@@ hw/rtl/mwma_pkg.sv @@
// Shared types, widths and window constants for the multi-window min/max/average block.
// Used by mwma_cell, mwma_emit and the top level. No dependencies.
package mwma_pkg;

    localparam int NUM_WIN  = 3;
    localparam int ID_W     = 2;
    localparam int SAMPLE_W = 16;
    localparam int CNT_W    = 6;
    localparam int SUM_W    = 23;
    // |sum| <= 63 * 32768 < 2**21
    localparam int ABS_W    = 21;

    localparam int SHORT_LEN  = 5;
    localparam int MEDIUM_LEN = 30;
    localparam int LONG_LEN   = 60;

    // floor(a / d) == (a * ceil(2**S / d)) >> S for a < 2**ABS_W, d < 2**CNT_W
    localparam int RECIP_SHIFT = ABS_W + CNT_W;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = ABS_W + RECIP_W;
    localparam int QUO_W       = PROD_W - RECIP_SHIFT;

    localparam logic [CNT_W-1:0] WIN_LEN [NUM_WIN] = '{
        CNT_W'(SHORT_LEN), CNT_W'(MEDIUM_LEN), CNT_W'(LONG_LEN)
    };

    localparam logic [RECIP_W-1:0] WIN_RECIP [NUM_WIN] = '{
        RECIP_W'((2 ** RECIP_SHIFT + SHORT_LEN - 1) / SHORT_LEN),
        RECIP_W'((2 ** RECIP_SHIFT + MEDIUM_LEN - 1) / MEDIUM_LEN),
        RECIP_W'((2 ** RECIP_SHIFT + LONG_LEN - 1) / LONG_LEN)
    };

    // One closed-window result before the divide
    typedef struct packed {
        logic                valid;
        logic [SAMPLE_W-1:0] max_val;
        logic [SAMPLE_W-1:0] min_val;
        logic                neg;
        logic [ABS_W-1:0]    abs_sum;
    } slot_t;

    // What travels along the chain: the sample and the slots filled so far
    typedef struct packed {
        logic [SAMPLE_W-1:0]        sample;
        slot_t [NUM_WIN-1:0]        slots;
    } bundle_t;

endpackage

@@ hw/rtl/mwma_cell.sv @@
// One window cell of the chain: running count/max/min/sum and a bundle register.
// Depends on mwma_pkg.
module mwma_cell (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [mwma_pkg::ID_W-1:0] cell_idx,
    input  logic                      in_valid,
    input  mwma_pkg::bundle_t         in_bundle,
    output logic                      in_ready,
    output logic                      out_valid,
    output mwma_pkg::bundle_t         out_bundle,
    input  logic                      out_ready
);
    import mwma_pkg::*;

    logic [CNT_W-1:0]           count_reg, count_next;
    logic signed [SAMPLE_W-1:0] max_reg, max_next;
    logic signed [SAMPLE_W-1:0] min_reg, min_next;
    logic signed [SUM_W-1:0]    sum_reg, sum_next;
    logic                       out_valid_reg;
    bundle_t                    bundle_reg, bundle_next;

    logic signed [SAMPLE_W-1:0] smp;
    logic                       first;
    logic                       close;
    logic                       load;
    logic [CNT_W-1:0]           cnt_inc;
    logic signed [SUM_W-1:0]    sum_base;
    logic [SUM_W-1:0]           sum_abs;

    assign smp      = $signed(in_bundle.sample);
    assign first    = (count_reg == '0);
    assign in_ready = !out_valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb begin
        max_next = (first || (smp > max_reg)) ? smp : max_reg;
        min_next = (first || (smp < min_reg)) ? smp : min_reg;
        sum_base = first ? '0 : sum_reg;
        sum_next = sum_base + {{(SUM_W - SAMPLE_W){smp[SAMPLE_W-1]}}, smp};
        cnt_inc  = count_reg + CNT_W'(1);
        close    = (cnt_inc >= WIN_LEN[cell_idx]);
        // closed window starts empty: stats are overwritten by the next sample
        count_next = close ? '0 : cnt_inc;
        sum_abs    = sum_next[SUM_W-1] ? $unsigned(-sum_next) : $unsigned(sum_next);

        bundle_next = in_bundle;
        bundle_next.slots[cell_idx].valid   = close;
        bundle_next.slots[cell_idx].max_val = max_next;
        bundle_next.slots[cell_idx].min_val = min_next;
        bundle_next.slots[cell_idx].neg     = sum_next[SUM_W-1];
        bundle_next.slots[cell_idx].abs_sum = sum_abs[ABS_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                count_reg <= count_next;
            end
            if (load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            max_reg    <= max_next;
            min_reg    <= min_next;
            sum_reg    <= sum_next;
            bundle_reg <= bundle_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_bundle = bundle_reg;

endmodule

@@ hw/rtl/mwma_emit.sv @@
// Result serializer: walks the closed slots of a bundle, divides by the window length
// through a reciprocal multiply, and drives the output register. Depends on mwma_pkg.
module mwma_emit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          b_valid,
    input  mwma_pkg::bundle_t             b_bundle,
    output logic                          b_ready,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [mwma_pkg::ID_W-1:0]     m_window_id,
    output logic [mwma_pkg::SAMPLE_W-1:0] m_window_max,
    output logic [mwma_pkg::SAMPLE_W-1:0] m_window_min,
    output logic [mwma_pkg::SAMPLE_W-1:0] m_window_avg,
    output logic                          m_last
);
    import mwma_pkg::*;

    logic [NUM_WIN-1:0]  done_reg;
    logic [NUM_WIN-1:0]  pend;
    logic [NUM_WIN-1:0]  rem;
    logic [ID_W-1:0]     sel_idx;
    logic                found;
    slot_t               sel_slot;
    logic                issue;
    logic                mul_ready;
    logic                out_ready;
    logic [PROD_W-1:0]   prod;

    logic                mul_valid_reg;
    logic [ID_W-1:0]     mul_id_reg;
    logic [SAMPLE_W-1:0] mul_max_reg;
    logic [SAMPLE_W-1:0] mul_min_reg;
    logic                mul_neg_reg;
    logic                mul_last_reg;
    logic [PROD_W-1:0]   mul_prod_reg;

    logic                m_valid_reg;
    logic [ID_W-1:0]     id_reg;
    logic [SAMPLE_W-1:0] max_reg;
    logic [SAMPLE_W-1:0] min_reg;
    logic [SAMPLE_W-1:0] avg_reg, avg_next;
    logic                last_reg;
    logic [QUO_W-1:0]    quo;

    always_comb begin
        for (int i = 0; i < NUM_WIN; i++) begin
            pend[i] = b_bundle.slots[i].valid && !done_reg[i];
        end
        sel_idx = '0;
        found   = 1'b0;
        for (int i = 0; i < NUM_WIN; i++) begin
            if (pend[i] && !found) begin
                sel_idx = ID_W'(i);
                found   = 1'b1;
            end
        end
        sel_slot = b_bundle.slots[sel_idx];
        rem      = pend & ~(NUM_WIN'(1) << sel_idx);
        prod     = PROD_W'(sel_slot.abs_sum) * PROD_W'(WIN_RECIP[sel_idx]);
    end

    assign out_ready = !m_valid_reg || m_ready;
    assign mul_ready = !mul_valid_reg || out_ready;
    assign issue     = b_valid && found && mul_ready;
    // bundle leaves once its last closed slot is issued, or at once if none closed
    assign b_ready   = !found || (mul_ready && (rem == '0));

    assign quo      = mul_prod_reg[PROD_W-1:RECIP_SHIFT];
    assign avg_next = mul_neg_reg ? SAMPLE_W'(-quo) : SAMPLE_W'(quo);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg      <= '0;
            mul_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (b_valid && b_ready) begin
                done_reg <= '0;
            end else if (issue) begin
                done_reg <= done_reg | (NUM_WIN'(1) << sel_idx);
            end
            if (mul_ready) begin
                mul_valid_reg <= issue;
            end
            if (out_ready) begin
                m_valid_reg <= mul_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            mul_id_reg   <= sel_idx;
            mul_max_reg  <= sel_slot.max_val;
            mul_min_reg  <= sel_slot.min_val;
            mul_neg_reg  <= sel_slot.neg;
            mul_last_reg <= (rem == '0);
            mul_prod_reg <= prod;
        end
        if (out_ready && mul_valid_reg) begin
            id_reg   <= mul_id_reg;
            max_reg  <= mul_max_reg;
            min_reg  <= mul_min_reg;
            avg_reg  <= avg_next;
            last_reg <= mul_last_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_window_id  = id_reg;
    assign m_window_max = max_reg;
    assign m_window_min = min_reg;
    assign m_window_avg = avg_reg;
    assign m_last       = last_reg;

endmodule

@@ hw/rtl/multi_window_min_max_average.sv @@
// Top level of the multi-window min/max/average block: three window cells in a chain
// and the result serializer. Depends on mwma_pkg, mwma_cell and mwma_emit.
//
//   channel | ports                                          | dir | moves
//   --------+------------------------------------------------+-----+-------------------------
//   input   | s_valid s_ready s_sample                       | in  | one sample per transfer
//   result  | m_valid m_ready m_window_id m_window_max       | out | one closed window per
//           | m_window_min m_window_avg m_last               |     | transfer
//
// Serializer: a sample that closes no window passes straight through; one that closes n
//   windows holds the serializer until its n results have issued (three at most, when all
//   windows close together), since the shared reciprocal multiplier issues one result per
//   cycle while the output is not stalled. A sample passes the three cell registers, the
//   multiply register and the output register before its first result.
// Reset: clears the fill counts and all valid flags; no clearing pass is needed.
// Stalls: m_ready low fills the output register, the multiply stage and the cell registers
//   in turn; s_ready drops only once all cell registers are full.
module multi_window_min_max_average (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [mwma_pkg::SAMPLE_W-1:0] s_sample,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [mwma_pkg::ID_W-1:0]     m_window_id,
    output logic [mwma_pkg::SAMPLE_W-1:0] m_window_max,
    output logic [mwma_pkg::SAMPLE_W-1:0] m_window_min,
    output logic [mwma_pkg::SAMPLE_W-1:0] m_window_avg,
    output logic                          m_last
);
    import mwma_pkg::*;

    // link[k] feeds cell k; link[NUM_WIN] feeds the serializer
    logic    link_valid [NUM_WIN+1];
    logic    link_ready [NUM_WIN+1];
    bundle_t link_bundle [NUM_WIN+1];

    // fresh bundle: the sample, with no window closed yet
    assign link_bundle[0] = '{sample: s_sample, slots: '0};
    assign link_valid[0]  = s_valid;
    assign s_ready        = link_ready[0];

    // cell k owns window k (short, medium, long) and fills slot k of the bundle
    for (genvar g = 0; g < NUM_WIN; g++) begin : g_cell
        mwma_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cell_idx   (ID_W'(g)),
            .in_valid   (link_valid[g]),
            .in_bundle  (link_bundle[g]),
            .in_ready   (link_ready[g]),
            .out_valid  (link_valid[g+1]),
            .out_bundle (link_bundle[g+1]),
            .out_ready  (link_ready[g+1])
        );
    end

    // slots go out in window order, last flag on the final one of each sample
    mwma_emit u_emit (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .b_valid      (link_valid[NUM_WIN]),
        .b_bundle     (link_bundle[NUM_WIN]),
        .b_ready      (link_ready[NUM_WIN]),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_window_id  (m_window_id),
        .m_window_max (m_window_max),
        .m_window_min (m_window_min),
        .m_window_avg (m_window_avg),
        .m_last       (m_last)
    );

endmodule

@@ hw/rtl/mwma_check.sv @@
// Port-level checks for the multi-window min/max/average block, bound to the top level.
// Depends on mwma_pkg.
module mwma_check (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 m_valid,
    input logic                                 m_ready,
    input logic [mwma_pkg::ID_W-1:0]            m_window_id,
    input logic signed [mwma_pkg::SAMPLE_W-1:0] m_window_max,
    input logic signed [mwma_pkg::SAMPLE_W-1:0] m_window_min,
    input logic signed [mwma_pkg::SAMPLE_W-1:0] m_window_avg,
    input logic                                 m_last
);
    import mwma_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_window_id) && $stable(m_window_avg)
            && $stable(m_window_max) && $stable(m_window_min) && $stable(m_last))
        else $error("result changed while stalled");

    a_id: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_window_id < ID_W'(NUM_WIN)))
        else $error("window id out of range");

    // average lies between the window's extremes
    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_window_min <= m_window_avg) && (m_window_avg <= m_window_max))
        else $error("average outside min/max");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind multi_window_min_max_average mwma_check u_mwma_check (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_window_id  (m_window_id),
    .m_window_max (m_window_max),
    .m_window_min (m_window_min),
    .m_window_avg (m_window_avg),
    .m_last       (m_last)
);
